### hdl/sss_pkg.sv
package sss_pkg;

   // request operation codes
   localparam logic [1:0] OP_QUERY  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // fixed field widths
   localparam int KEY_W       = 32;
   localparam int OP_W        = 2;
   localparam int COUNT_OUT_W = 9;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PROBE,
      ST_SHIFT,
      ST_WRITE_KEY,
      ST_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic probe_issue;
      logic probe_eval;
      logic shift_start;
      logic shift_step;
      logic write_key;
      logic count_inc;
      logic count_dec;
      logic mark_refused;
      logic result_load;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic search_done;
      logic insert_new;
      logic remove_hit;
      logic full;
      logic shift_done;
      logic dir_up;
   } dp_sts_type;

endpackage

### hdl/sorted_set_store_top.sv
// channel   direction  valid      stall      payload
// req       in         req_valid  req_stall  req_operation, req_key
// rsp       out        rsp_valid  rsp_stall  rsp_was_present, rsp_stored_count,
//                                            rsp_rejected_full
//
// one request at a time: accept, search probes (at most ceil(log2(count+1))), shift of the moved
// entries for a new insert with room or a hit remove, key write for an insert, then result
// the shift moves one entry per cycle through the store ram's one read port and one write port
// reset clears the count; store contents stay undefined and are never read before written
// a new request is taken while a finished result still waits on a stalled rsp channel
module sorted_set_store_top #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_was_present,
   output logic [8:0]         rsp_stored_count,
   output logic               rsp_rejected_full
);
   import sss_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencing
   sss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // search, shift and store
   sss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .rsp_was_present   (rsp_was_present),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_rejected_full (rsp_rejected_full)
   );

endmodule

### hdl/sss_ram.sv
module sss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sss_datapath.sv
module sss_datapath #(
   parameter int CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sss_pkg::dp_cmd_type               cmd,
   output sss_pkg::dp_sts_type               sts,
   input  logic [1:0]                        req_operation,
   input  logic signed [31:0]                req_key,
   output logic                              rsp_was_present,
   output logic [8:0]                        rsp_stored_count,
   output logic                              rsp_rejected_full
);
   import sss_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // request registers
   logic [OP_W-1:0]         op_ff;
   logic signed [KEY_W-1:0] key_ff;

   // search and shift registers
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] mid_ff;
   logic          found_ff, found_in;
   logic          refused_ff, refused_in;
   logic          dir_up_ff;
   logic          wr_pend_ff;
   logic [AW-1:0] wr_addr_ff;

   // result registers
   logic                   was_present_ff;
   logic [COUNT_OUT_W-1:0] stored_count_ff;
   logic                   rejected_full_ff;

   // ram signals
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;

   logic [CW-1:0] span;
   logic [CW-1:0] mid_full;
   logic [CW-1:0] ptr_dec;
   logic [CW-1:0] ptr_inc;
   logic [AW-1:0] shift_rd_addr;

   sss_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // midpoint of the search window and shift pointer neighbors
   assign span     = hi_ff - lo_ff;
   assign mid_full = lo_ff + (span >> 1);
   assign ptr_dec  = ptr_ff - 1'b1;
   assign ptr_inc  = ptr_ff + 1'b1;
   assign shift_rd_addr = dir_up_ff ? ptr_dec[AW-1:0] : ptr_ff[AW-1:0];

   // memory port muxing: pending shift write or final key write
   always_comb begin
      ram_rd_en   = cmd.probe_issue | cmd.shift_step;
      ram_rd_addr = cmd.shift_step ? shift_rd_addr : mid_full[AW-1:0];
      ram_wr_en   = wr_pend_ff | cmd.write_key;
      ram_wr_addr = cmd.write_key ? lo_ff[AW-1:0] : wr_addr_ff;
      ram_wr_data = cmd.write_key ? key_ff : ram_rd_data;
   end

   // next values of search window, count and flags
   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      found_in   = found_ff;
      refused_in = refused_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      if (cmd.load) begin
         lo_in      = '0;
         hi_in      = count_ff;
         found_in   = 1'b0;
         refused_in = 1'b0;
      end
      if (cmd.probe_eval) begin
         if ($signed(ram_rd_data) < key_ff) begin
            lo_in = CW'(mid_ff) + 1'b1;
         end else begin
            hi_in = CW'(mid_ff);
         end
         if (ram_rd_data == key_ff) begin
            found_in = 1'b1;
         end
      end
      if (cmd.mark_refused) begin
         refused_in = 1'b1;
      end
      if (cmd.shift_start) begin
         ptr_in = (op_ff == OP_INSERT) ? count_ff : (lo_ff + 1'b1);
      end
      if (cmd.shift_step) begin
         ptr_in = dir_up_ff ? ptr_dec : ptr_inc;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         wr_pend_ff <= cmd.shift_step;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      found_ff   <= found_in;
      refused_ff <= refused_in;
      wr_addr_ff <= dir_up_ff ? ptr_ff[AW-1:0] : ptr_dec[AW-1:0];
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
      end
      if (cmd.probe_issue) begin
         mid_ff <= mid_full[AW-1:0];
      end
      if (cmd.shift_start) begin
         dir_up_ff <= (op_ff == OP_INSERT);
      end
      if (cmd.result_load) begin
         was_present_ff   <= found_ff;
         stored_count_ff  <= COUNT_OUT_W'(count_ff);
         rejected_full_ff <= refused_ff;
      end
   end

   // status toward the controller
   always_comb begin
      sts.search_done = (lo_ff >= hi_ff);
      sts.insert_new  = (op_ff == OP_INSERT) && !found_ff;
      sts.remove_hit  = (op_ff == OP_REMOVE) && found_ff;
      sts.full        = (count_ff == CW'(CAPACITY));
      sts.shift_done  = dir_up_ff ? (ptr_ff == lo_ff) : (ptr_ff == count_ff);
      sts.dir_up      = dir_up_ff;
   end

   assign rsp_was_present   = was_present_ff;
   assign rsp_stored_count  = stored_count_ff;
   assign rsp_rejected_full = rejected_full_ff;

   // count never passes the store size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   // search window never inverts
   assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search window inverted");

   // shift write and key write never collide on the single write port
   assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && cmd.write_key))
      else $error("write port conflict");

   // a key is only placed into a store that has room
   assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> (count_ff < CW'(CAPACITY)))
      else $error("insert into full store");

endmodule

### hdl/sss_ctrl.sv
module sss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sss_pkg::dp_cmd_type cmd,
   input  sss_pkg::dp_sts_type sts
);
   import sss_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (!sts.search_done) begin
               cmd.probe_issue = 1'b1;
               state_in        = ST_PROBE;
            end else if (sts.insert_new && sts.full) begin
               cmd.mark_refused = 1'b1;
               state_in         = ST_RESULT;
            end else if (sts.insert_new || sts.remove_hit) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_PROBE: begin
            cmd.probe_eval = 1'b1;
            state_in       = ST_SEARCH;
         end
         ST_SHIFT: begin
            if (!sts.shift_done) begin
               cmd.shift_step = 1'b1;
            end else if (sts.dir_up) begin
               state_in = ST_WRITE_KEY;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_WRITE_KEY: begin
            cmd.write_key = 1'b1;
            cmd.count_inc = 1'b1;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register holds until taken
   assign rsp_valid_in = cmd.result_load | (rsp_valid_ff & rsp_stall);

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted request starts a search
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SEARCH))
      else $error("accepted request did not start search");

   // a new result appears only out of the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result without finished request");

endmodule
